>>> hw/rtl/assert_macros.svh
// Assertion shorthands included by the controller top level.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/jric_pkg.sv
// Shared types, codes and constants of the joint ramp and impedance controller.
// No dependencies.
package jric_pkg;

    localparam int unsigned Q_W        = 32;
    localparam int unsigned GAIN_W     = 31;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned JOINT_W    = 5;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 31;

    // Register reset values (tolerance 0.9 and step 66/65536 s in unsigned Q15.16).
    localparam logic [GAIN_W-1:0] TOL_RESET  = 31'd58982;
    localparam logic [GAIN_W-1:0] STEP_RESET = 31'd66;
    localparam logic [TICK_W-1:0] DIV_RESET  = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE  = 2'd0,
        REG_STEP_SCALE = 2'd1,
        REG_DIVIDER    = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_POSITION  = 3'd0,
        MODE_VELOCITY  = 3'd1,
        MODE_TORQUE    = 3'd2,
        MODE_OPEN_LOOP = 3'd3,
        MODE_IMPEDANCE = 3'd4
    } mode_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_POSITION = 2'd0,
        CMD_VELOCITY = 2'd1,
        CMD_TORQUE   = 2'd2
    } cmd_kind_t;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [Q_W-1:0] sat32(input logic signed [51:0] v);
        logic [Q_W-1:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -52'sd2147483648) begin
            r = 32'h8000_0000;
        end
        else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/joint_ramp_impedance_controller.sv
// Top level of the per-joint set-point ramp with impedance PD control law.
// Depends on jric_pkg and on assert_macros.svh.
//
//  channel   handshake                 words
//  --------  ------------------------  ----------------------------------------
//  item      item_valid / item_stall   load or control tick for one joint
//  result    result_valid / result_st  command for one joint (ticks that run)
//  config    cfg_wen                   tolerance, step scale, divider
//
// One word is accepted per cycle unless the stalled output holds the pipeline.
// The rate is set by the per-joint state memory: its read-modify-write sits in
// one stage and a write-back record forwards to the next tick of the same joint.
// Reset leaves per-joint entries invalid; an invalid entry reads as zero, so no
// clearing pass is needed. A stalled result freezes the whole pipeline.
module joint_ramp_impedance_controller #(
    parameter int NUM_JOINTS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wen,
    input  logic [jric_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jric_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 kind,
    input  logic [jric_pkg::JOINT_W-1:0]         joint,
    input  logic                                 first_of_tick,
    input  logic [jric_pkg::MODE_W-1:0]          mode,
    input  logic signed [jric_pkg::Q_W-1:0]      ref_position,
    input  logic signed [jric_pkg::Q_W-1:0]      ref_speed,
    input  logic signed [jric_pkg::Q_W-1:0]      aux_reference,
    input  logic signed [jric_pkg::Q_W-1:0]      measured_position,
    input  logic signed [jric_pkg::Q_W-1:0]      measured_speed,
    input  logic [jric_pkg::GAIN_W-1:0]          stiffness,
    input  logic [jric_pkg::GAIN_W-1:0]          damping,
    input  logic signed [jric_pkg::Q_W-1:0]      zero_position,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [jric_pkg::JOINT_W-1:0]         out_joint,
    output logic [jric_pkg::CMD_W-1:0]           command_kind,
    output logic signed [jric_pkg::Q_W-1:0]      command_value,
    output logic                                 motion_done
);
    import jric_pkg::*;

    localparam int AW      = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam int STATE_W = Q_W + 1;
    localparam int PARAM_W = 2 * GAIN_W + 2 * Q_W;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     refp;
        logic [Q_W-1:0]     refv;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     mpos;
        logic [Q_W-1:0]     mspd;
    } s1_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     refp;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     mpos;
        logic [Q_W-1:0]     mspd;
        logic [47:0]        step;
    } s2_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     mpos;
        logic [Q_W-1:0]     mspd;
        logic [Q_W-1:0]     des;
        logic               done;
        logic [GAIN_W-1:0]  k;
        logic [GAIN_W-1:0]  d;
        logic [Q_W-1:0]     zero;
        logic [Q_W-1:0]     off;
    } s3_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     des;
        logic               done;
        logic [GAIN_W-1:0]  k;
        logic [Q_W-1:0]     off;
        logic [33:0]        err;
        logic [63:0]        dprod;
    } s4_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     des;
        logic               done;
        logic [Q_W-1:0]     off;
        logic [63:0]        dprod;
        logic [47:0]        plo;
        logic [48:0]        phi;
    } s5_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [MODE_W-1:0]  mode;
        logic [Q_W-1:0]     aux;
        logic [Q_W-1:0]     des;
        logic               done;
        logic [Q_W-1:0]     off;
        logic [63:0]        dprod;
        logic [65:0]        kprod;
    } s6_t;

    // Configuration and tick counter.
    logic [GAIN_W-1:0] tol_reg;
    logic [GAIN_W-1:0] step_reg;
    logic [TICK_W-1:0] div_reg;
    logic [TICK_W-1:0] tick_count_reg;
    logic [TICK_W-1:0] tick_count_next;
    logic [TICK_W-1:0] div_eff;
    logic [TICK_W:0]   tc_inc;

    // Pipeline registers.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    s1_t  s1_reg;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    s4_t  s4_reg, s4_next;
    s5_t  s5_reg, s5_next;
    s6_t  s6_reg, s6_next;

    // Per-joint memories, valid bits and the write-back record.
    logic [STATE_W-1:0]    state_mem [NUM_JOINTS];
    logic [PARAM_W-1:0]    param_mem [NUM_JOINTS];
    logic [STATE_W-1:0]    state_q_reg;
    logic [PARAM_W-1:0]    param_q_reg;
    logic [NUM_JOINTS-1:0] state_vld_reg;
    logic [NUM_JOINTS-1:0] param_vld_reg;
    logic                  state_vq_reg;
    logic                  param_vq_reg;
    logic                  fw_vld_reg;
    logic [JOINT_W-1:0]    fw_joint_reg;
    logic [STATE_W-1:0]    fw_state_reg;

    // Output register.
    logic                 result_valid_reg;
    logic [JOINT_W-1:0]   out_joint_reg;
    logic [CMD_W-1:0]     command_kind_reg;
    logic [Q_W-1:0]       command_value_reg;
    logic                 motion_done_reg;
    logic [CMD_W-1:0]     command_kind_next;
    logic [Q_W-1:0]       command_value_next;

    logic          adv;
    logic          accept;
    logic          is_tick;
    logic          in_range;
    logic          run;
    logic          load_wr;
    logic          state_wr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] s2_addr;
    logic [AW-1:0] ld_addr;

    logic signed [63:0] step_prod;
    logic [STATE_W-1:0] state_cur;
    logic [Q_W-1:0]     des_cur;
    logic               done_cur;
    logic [PARAM_W-1:0] param_cur;
    logic signed [32:0] e;
    logic signed [33:0] e_x;
    logic signed [33:0] tol_s;
    logic signed [33:0] low_sum;
    logic               below;
    logic               above;
    logic               out_band;
    logic               ramp;
    logic signed [51:0] moved;
    logic [Q_W-1:0]     st_des_new;
    logic               st_done_new;
    logic signed [51:0] torque;

    // The pipeline moves as one; a stalled full output register freezes it.
    assign adv        = !result_valid_reg || !result_stall;
    assign item_stall = !adv;
    assign accept     = item_valid && adv;

    // Item decode and tick counter advance.
    assign is_tick  = (kind == KIND_TICK);
    assign in_range = (int'(joint) < NUM_JOINTS);
    assign div_eff  = (div_reg == '0) ? TICK_W'(1) : div_reg;
    assign tc_inc   = {1'b0, tick_count_reg} + (TICK_W + 1)'(1);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        if (is_tick && first_of_tick) begin
            tick_count_next = (tc_inc >= {1'b0, div_eff}) ? '0 : tc_inc[TICK_W-1:0];
        end
    end

    assign run = is_tick && (tick_count_next == '0) && in_range &&
                 (mode inside {[MODE_POSITION:MODE_IMPEDANCE]});
    assign load_wr = accept && !is_tick && in_range;

    assign rd_addr = AW'(s1_reg.joint);
    assign s2_addr = AW'(s2_reg.joint);
    assign ld_addr = AW'(joint);

    // Configuration writes and the tick counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tol_reg        <= TOL_RESET;
            step_reg       <= STEP_RESET;
            div_reg        <= DIV_RESET;
            tick_count_reg <= '0;
        end
        else begin
            if (accept) begin
                tick_count_reg <= tick_count_next;
            end
            if (cfg_wen) begin
                case (cfg_reg_t'(cfg_index))
                    REG_TOLERANCE:  tol_reg  <= cfg_data[GAIN_W-1:0];
                    REG_STEP_SCALE: step_reg <= cfg_data[GAIN_W-1:0];
                    REG_DIVIDER:    div_reg  <= cfg_data[TICK_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Stage 1: ramp step, the exact product floored to Q32.16.
    assign step_prod = 64'($signed({1'b0, step_reg})) * 64'($signed(s1_reg.refv));

    always_comb
    begin
        s2_next.joint = s1_reg.joint;
        s2_next.mode  = s1_reg.mode;
        s2_next.refp  = s1_reg.refp;
        s2_next.aux   = s1_reg.aux;
        s2_next.mpos  = s1_reg.mpos;
        s2_next.mspd  = s1_reg.mspd;
        s2_next.step  = step_prod[63:16];
    end

    // Stage 2: read-modify-write of the joint's desired position and done flag.
    assign state_cur = (fw_vld_reg && (fw_joint_reg == s2_reg.joint)) ? fw_state_reg :
                       (state_vq_reg ? state_q_reg : '0);
    assign des_cur   = state_cur[Q_W-1:0];
    assign done_cur  = state_cur[Q_W];
    assign param_cur = param_vq_reg ? param_q_reg : '0;

    assign e       = 33'($signed(des_cur)) - 33'($signed(s2_reg.refp));
    assign e_x     = 34'(e);
    assign tol_s   = $signed({3'b000, tol_reg});
    assign low_sum = e_x + tol_s;
    assign below   = low_sum[33];
    assign above   = e_x > tol_s;
    assign out_band = below || above;

    assign moved = below ? (52'($signed(des_cur)) + 52'($signed(s2_reg.step)))
                         : (52'($signed(des_cur)) - 52'($signed(s2_reg.step)));
    assign st_des_new  = out_band ? sat32(moved) : s2_reg.refp;
    assign st_done_new = !out_band;

    assign ramp     = (s2_reg.mode == MODE_POSITION) || (s2_reg.mode == MODE_IMPEDANCE);
    assign state_wr = adv && s2_vld_reg && ramp;

    always_comb
    begin
        s3_next.joint = s2_reg.joint;
        s3_next.mode  = s2_reg.mode;
        s3_next.aux   = s2_reg.aux;
        s3_next.mpos  = s2_reg.mpos;
        s3_next.mspd  = s2_reg.mspd;
        s3_next.des   = ramp ? st_des_new : des_cur;
        s3_next.done  = ramp ? st_done_new : done_cur;
        s3_next.k     = param_cur[PARAM_W-1 -: GAIN_W];
        s3_next.d     = param_cur[2*Q_W+GAIN_W-1 -: GAIN_W];
        s3_next.zero  = param_cur[2*Q_W-1 -: Q_W];
        s3_next.off   = param_cur[Q_W-1:0];
    end

    // Stage 3: position error and the damping product.
    always_comb
    begin
        s4_next.joint = s3_reg.joint;
        s4_next.mode  = s3_reg.mode;
        s4_next.aux   = s3_reg.aux;
        s4_next.des   = s3_reg.des;
        s4_next.done  = s3_reg.done;
        s4_next.k     = s3_reg.k;
        s4_next.off   = s3_reg.off;
        s4_next.err   = 34'($signed(s3_reg.mpos)) - 34'($signed(s3_reg.zero))
                        - 34'($signed(s3_reg.des));
        s4_next.dprod = 64'($signed({1'b0, s3_reg.d})) * 64'($signed(s3_reg.mspd));
    end

    // Stage 4: stiffness times error as two partial products.
    always_comb
    begin
        s5_next.joint = s4_reg.joint;
        s5_next.mode  = s4_reg.mode;
        s5_next.aux   = s4_reg.aux;
        s5_next.des   = s4_reg.des;
        s5_next.done  = s4_reg.done;
        s5_next.off   = s4_reg.off;
        s5_next.dprod = s4_reg.dprod;
        s5_next.plo   = 48'(s4_reg.k) * 48'(s4_reg.err[16:0]);
        s5_next.phi   = 49'($signed({1'b0, s4_reg.k})) * 49'($signed(s4_reg.err[33:17]));
    end

    // Stage 5: combine the partial products.
    always_comb
    begin
        s6_next.joint = s5_reg.joint;
        s6_next.mode  = s5_reg.mode;
        s6_next.aux   = s5_reg.aux;
        s6_next.des   = s5_reg.des;
        s6_next.done  = s5_reg.done;
        s6_next.off   = s5_reg.off;
        s6_next.dprod = s5_reg.dprod;
        s6_next.kprod = (66'($signed(s5_reg.phi)) <<< 17) + $signed({18'd0, s5_reg.plo});
    end

    // Stage 6: torque sum, saturation and command selection.
    assign torque = 52'($signed(s6_reg.off)) - 52'($signed(s6_reg.kprod[65:16]))
                    - 52'($signed(s6_reg.dprod[63:16]));

    always_comb
    begin
        case (s6_reg.mode)
            MODE_POSITION:
            begin
                command_kind_next  = CMD_POSITION;
                command_value_next = s6_reg.des;
            end
            MODE_IMPEDANCE:
            begin
                command_kind_next  = CMD_TORQUE;
                command_value_next = sat32(torque);
            end
            MODE_VELOCITY:
            begin
                command_kind_next  = CMD_VELOCITY;
                command_value_next = s6_reg.aux;
            end
            default:
            begin
                command_kind_next  = CMD_TORQUE;
                command_value_next = s6_reg.aux;
            end
        endcase
    end

    // Stage valid bits, memory valid bits and the write-back record flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_vld_reg       <= 1'b0;
            s2_vld_reg       <= 1'b0;
            s3_vld_reg       <= 1'b0;
            s4_vld_reg       <= 1'b0;
            s5_vld_reg       <= 1'b0;
            s6_vld_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
            fw_vld_reg       <= 1'b0;
            state_vld_reg    <= '0;
            param_vld_reg    <= '0;
            state_vq_reg     <= 1'b0;
            param_vq_reg     <= 1'b0;
        end
        else begin
            if (state_wr) begin
                state_vld_reg[s2_addr] <= 1'b1;
            end
            if (load_wr) begin
                param_vld_reg[ld_addr] <= 1'b1;
            end
            if (adv) begin
                s1_vld_reg       <= accept && run;
                s2_vld_reg       <= s1_vld_reg;
                s3_vld_reg       <= s2_vld_reg;
                s4_vld_reg       <= s3_vld_reg;
                s5_vld_reg       <= s4_vld_reg;
                s6_vld_reg       <= s5_vld_reg;
                result_valid_reg <= s6_vld_reg;
                fw_vld_reg       <= state_wr;
                state_vq_reg     <= state_vld_reg[rd_addr];
                param_vq_reg     <= param_vld_reg[rd_addr];
            end
        end
    end

    // Stage payloads and the output word.
    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_reg.joint      <= joint;
            s1_reg.mode       <= mode;
            s1_reg.refp       <= ref_position;
            s1_reg.refv       <= ref_speed;
            s1_reg.aux        <= aux_reference;
            s1_reg.mpos       <= measured_position;
            s1_reg.mspd       <= measured_speed;
            s2_reg            <= s2_next;
            s3_reg            <= s3_next;
            s4_reg            <= s4_next;
            s5_reg            <= s5_next;
            s6_reg            <= s6_next;
            fw_joint_reg      <= s2_reg.joint;
            fw_state_reg      <= {st_done_new, st_des_new};
            out_joint_reg     <= s6_reg.joint;
            command_kind_reg  <= command_kind_next;
            command_value_reg <= command_value_next;
            motion_done_reg   <= s6_reg.done;
        end
    end

    // Joint state memory: written by the ramp stage, read as a tick enters it.
    always_ff @(posedge clk)
    begin
        if (state_wr) begin
            state_mem[s2_addr] <= {st_done_new, st_des_new};
        end
        if (adv) begin
            state_q_reg <= state_mem[rd_addr];
        end
    end

    // Joint settings memory: written by load words, read alongside the state.
    always_ff @(posedge clk)
    begin
        if (load_wr) begin
            param_mem[ld_addr] <= {stiffness, damping, zero_position, aux_reference};
        end
        if (adv) begin
            param_q_reg <= param_mem[rd_addr];
        end
    end

    assign result_valid  = result_valid_reg;
    assign out_joint     = out_joint_reg;
    assign command_kind  = command_kind_reg;
    assign command_value = command_value_reg;
    assign motion_done   = motion_done_reg;

    `include "assert_macros.svh"

    `ASSERT_NEXT(a_frozen_stage_holds, !adv, $stable(s1_vld_reg) && $stable(s1_reg), "stage 1 moved while the pipeline was frozen")
    `ASSERT_IMPL(a_snap_writes_reference, state_wr && st_done_new, st_des_new == s2_reg.refp, "done set without the reference as desired position")
    `ASSERT_NEXT(a_written_entry_valid, state_wr, state_vld_reg[$past(s2_addr)], "state entry written but not marked valid")
    `ASSERT_NEXT(a_unit_divider_wraps, accept && is_tick && first_of_tick && (div_eff == 8'd1), tick_count_reg == '0, "tick counter left zero with a divider of one")

endmodule
